@@ design/point_dedup_index_table_top_defines.svh @@
// assertion macros for the point dedup index table checker
`ifndef POINT_DEDUP_INDEX_TABLE_TOP_DEFINES_SVH
`define POINT_DEDUP_INDEX_TABLE_TOP_DEFINES_SVH

// plain condition that must hold at every clock edge out of reset
`define PDIT_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pdit: condition check failed");

// implication within the same cycle
`define PDIT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdit: same cycle implication failed");

// implication into the next cycle
`define PDIT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdit: next cycle implication failed");

`endif

@@ design/pdit_pkg.sv @@
// shared types, constants and the hash function of the point dedup index table
package pdit_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    // hash table has at least twice as many slots as points
    localparam int SLOT_W      = IDX_W + 1;
    localparam int SLOTS       = 2 ** SLOT_W;
    localparam int COORD_W     = 32;
    localparam int PIDX_W      = 8;
    localparam int ENTRY_W     = 9;
    localparam int RIDX_W      = 8;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_READ
    } state_t;

    // point entry keeps the hash slot that points at it, so stale slots show up
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [SLOT_W-1:0]  slot;
    } pt_entry_t;

    typedef struct packed {
        logic [SLOT_W-1:0] hash_rd_addr;
        logic              hash_we;
        logic [SLOT_W-1:0] hash_wr_addr;
        logic [IDX_W-1:0]  hash_wr_data;
        logic [IDX_W-1:0]  pt_rd_addr;
        logic              pt_we;
        logic [IDX_W-1:0]  pt_wr_addr;
        pt_entry_t         pt_wr_data;
    } store_req_t;

    function automatic logic [SLOT_W-1:0] pdit_hash(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [COORD_W-1:0] z
    );
        logic [COORD_W-1:0] mix;
        logic [SLOT_W-1:0]  res;
        mix = x ^ {y[20:0], y[31:21]} ^ {z[9:0], z[31:10]};
        res = '0;
        for (int i = 0; i < COORD_W; i++)
        begin
            res[i % SLOT_W] = res[i % SLOT_W] ^ mix[i];
        end
        return res;
    endfunction

endpackage

@@ design/pdit_store.sv @@
// hash slot memory and point memory, both with registered reads
module pdit_store
    import pdit_pkg::*;
(
    input  logic              clk,
    input  store_req_t        req,
    output logic [IDX_W-1:0]  hash_rd_data,
    output pt_entry_t         pt_rd_data
);

    logic [IDX_W-1:0] hash_mem [SLOTS];
    pt_entry_t        pt_mem   [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.hash_we)
        begin
            hash_mem[req.hash_wr_addr] <= req.hash_wr_data;
        end
        hash_rd_data <= hash_mem[req.hash_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (req.pt_we)
        begin
            pt_mem[req.pt_wr_addr] <= req.pt_wr_data;
        end
        pt_rd_data <= pt_mem[req.pt_rd_addr];
    end

endmodule

@@ design/point_dedup_index_table_top.sv @@
// point dedup index table: hashed lookup with linear probing over a point memory
//
//   channel  | handshake          | fields
//   ---------+--------------------+------------------------------------------------
//   item in  | start, busy        | func, point_x, point_y, point_z, read_index
//   result   | done (one cycle)   | point_index, was_present, status, entry_count,
//            |                    | read_x, read_y, read_z
//
// clear, unused func and out of range read: result in the cycle after the accepted beat.
// in range read: one point memory read, then the result registers.
// add: p probes; each probe is a hash slot read then a point read.
// the hash memory has twice as many slots as points, so p stays small on average.
// busy holds input off until the result cycle; the receiver cannot stall done.
// rst_n clears count and control only; stale slots fail the count or back-pointer check.
module point_dedup_index_table_top
    import pdit_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic [COORD_W-1:0] point_x,
    input  logic [COORD_W-1:0] point_y,
    input  logic [COORD_W-1:0] point_z,
    input  logic [RIDX_W-1:0]  read_index,
    output logic               done,
    output logic [PIDX_W-1:0]  point_index,
    output logic               was_present,
    output logic [1:0]         status,
    output logic [ENTRY_W-1:0] entry_count,
    output logic [COORD_W-1:0] read_x,
    output logic [COORD_W-1:0] read_y,
    output logic [COORD_W-1:0] read_z
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [COORD_W-1:0] px_reg, px_next;
    logic [COORD_W-1:0] py_reg, py_next;
    logic [COORD_W-1:0] pz_reg, pz_next;
    logic               done_reg, done_next;
    logic [PIDX_W-1:0]  pidx_reg, pidx_next;
    logic               present_reg, present_next;
    logic [1:0]         status_reg, status_next;
    logic [ENTRY_W-1:0] entry_reg, entry_next;
    logic [COORD_W-1:0] rx_reg, rx_next;
    logic [COORD_W-1:0] ry_reg, ry_next;
    logic [COORD_W-1:0] rz_reg, rz_next;

    store_req_t        req;
    logic [IDX_W-1:0]  hash_rd_data;
    pt_entry_t         pt_rd_data;
    logic              slot_valid;
    logic              slot_match;
    logic              read_in_range;

    pdit_store u_store (
        .clk          (clk),
        .req          (req),
        .hash_rd_data (hash_rd_data),
        .pt_rd_data   (pt_rd_data)
    );

    assign slot_valid = (CNT_W'(idx_reg) < count_reg) && (pt_rd_data.slot == slot_reg);
    assign slot_match = (pt_rd_data.x == px_reg) && (pt_rd_data.y == py_reg)
                        && (pt_rd_data.z == pz_reg);
    assign read_in_range = (32'(read_index) < 32'(count_reg));

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        slot_next    = slot_reg;
        idx_next     = idx_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        pz_next      = pz_reg;
        done_next    = 1'b0;
        pidx_next    = pidx_reg;
        present_next = present_reg;
        status_next  = status_reg;
        entry_next   = entry_reg;
        rx_next      = rx_reg;
        ry_next      = ry_reg;
        rz_next      = rz_reg;

        req              = '0;
        req.hash_rd_addr = slot_reg + SLOT_W'(1);
        req.pt_rd_addr   = hash_rd_data;
        req.pt_wr_addr   = count_reg[IDX_W-1:0];
        req.hash_wr_addr = slot_reg;
        req.hash_wr_data = count_reg[IDX_W-1:0];
        req.pt_wr_data   = '{x: px_reg, y: py_reg, z: pz_reg, slot: slot_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                req.hash_rd_addr = pdit_hash(point_x, point_y, point_z);
                req.pt_rd_addr   = IDX_W'(read_index);
                if (start)
                begin
                    px_next      = point_x;
                    py_next      = point_y;
                    pz_next      = point_z;
                    pidx_next    = '0;
                    present_next = 1'b0;
                    status_next  = STATUS_OK;
                    entry_next   = ENTRY_W'(count_reg);
                    rx_next      = '0;
                    ry_next      = '0;
                    rz_next      = '0;
                    unique case (func)
                        FUNC_ADD:
                        begin
                            slot_next  = pdit_hash(point_x, point_y, point_z);
                            state_next = ST_PROBE;
                        end
                        FUNC_CLEAR:
                        begin
                            count_next = '0;
                            entry_next = '0;
                            done_next  = 1'b1;
                        end
                        FUNC_READ:
                        begin
                            if (read_in_range)
                            begin
                                state_next = ST_READ;
                            end
                            else
                            begin
                                status_next = STATUS_RANGE;
                                done_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_PROBE:
            begin
                idx_next   = hash_rd_data;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (slot_valid && slot_match)
                begin
                    pidx_next    = PIDX_W'(idx_reg);
                    present_next = 1'b1;
                    done_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (slot_valid)
                begin
                    // occupied by another point, step to the next slot
                    slot_next  = slot_reg + SLOT_W'(1);
                    state_next = ST_PROBE;
                end
                else if (32'(count_reg) < 32'(TABLE_DEPTH))
                begin
                    req.pt_we   = 1'b1;
                    req.hash_we = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                    pidx_next   = PIDX_W'(count_reg);
                    entry_next  = ENTRY_W'(count_reg + CNT_W'(1));
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    status_next = STATUS_FULL;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_READ:
            begin
                rx_next    = pt_rd_data.x;
                ry_next    = pt_rd_data.y;
                rz_next    = pt_rd_data.z;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        idx_reg     <= idx_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        pz_reg      <= pz_next;
        pidx_reg    <= pidx_next;
        present_reg <= present_next;
        status_reg  <= status_next;
        entry_reg   <= entry_next;
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        rz_reg      <= rz_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign point_index = pidx_reg;
    assign was_present = present_reg;
    assign status      = status_reg;
    assign entry_count = entry_reg;
    assign read_x      = rx_reg;
    assign read_y      = ry_reg;
    assign read_z      = rz_reg;

endmodule

@@ design/pdit_checker.sv @@
// port level checks on the point dedup index table, bound to the top level
`include "point_dedup_index_table_top_defines.svh"

module pdit_checker
    import pdit_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [PIDX_W-1:0]  point_index,
    input logic               was_present,
    input logic [1:0]         status,
    input logic [ENTRY_W-1:0] entry_count,
    input logic [COORD_W-1:0] read_x,
    input logic [COORD_W-1:0] read_y,
    input logic [COORD_W-1:0] read_z
);

    // an accepted beat either keeps the block busy or answers at once
    `PDIT_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done)

    `PDIT_ASSERT_IMP(a_done_not_busy, done, !busy)

    // a hit is always ok and points below the count
    `PDIT_ASSERT_IMP(a_hit_in_table, done && was_present,
        (status == STATUS_OK) && ({1'b0, point_index} < entry_count))

    `PDIT_ASSERT_IMP(a_full_at_depth, done && (status == STATUS_FULL),
        (entry_count == ENTRY_W'(TABLE_DEPTH)) && !was_present)

    `PDIT_ASSERT_IMP(a_range_zero, done && (status == STATUS_RANGE),
        (read_x == '0) && (read_y == '0) && (read_z == '0) && (point_index == '0))

endmodule

bind point_dedup_index_table_top pdit_checker u_pdit_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .point_index (point_index),
    .was_present (was_present),
    .status      (status),
    .entry_count (entry_count),
    .read_x      (read_x),
    .read_y      (read_y),
    .read_z      (read_z)
);
